// ----- hdl/rbc_pkg.sv -----
// Shared types and constants for the rejoin backoff controller.
package rbc_pkg;

   // Highest transmit power step that auto mode climbs to
   localparam logic [2:0] MAX_POWER_LEVEL = 3'd4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 96;

   // Reset values of the configuration registers
   localparam logic [1:0]  MODE_RESET     = 2'd0;
   localparam logic [7:0]  TRIES_RESET    = 8'd4;
   localparam logic [31:0] START_RESET    = 32'd10000;
   localparam logic [4:0]  FACTOR_RESET   = 5'd2;
   localparam logic [31:0] MAX_RESET      = 32'd1800000;
   localparam logic [7:0]  DS_THR_RESET   = 8'd10;
   localparam logic [31:0] DS_INT_RESET   = 32'd3600000;
   localparam logic [7:0]  GU_THR_RESET   = 8'd20;

   localparam logic [1:0]  MODE_AUTO      = 2'd0;

   // Valid range of a logical channel for the quick rejoin
   localparam logic [4:0]  CHAN_FIRST     = 5'd11;
   localparam logic [4:0]  CHAN_LAST      = 5'd26;

   typedef enum logic [1:0] {
      OP_JOIN_OK         = 2'd0,
      OP_PARENT_RESTORED = 2'd1,
      OP_REJOIN_FAILED   = 2'd2,
      OP_KEY_PRESS       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_TX_POWER_MODE  = 3'd0,
      REG_RETRY_TRIES    = 3'd1,
      REG_START_DELAY    = 3'd2,
      REG_BACKOFF_FACTOR = 3'd3,
      REG_MAX_DELAY      = 3'd4,
      REG_DS_THRESHOLD   = 3'd5,
      REG_DS_INTERVAL    = 3'd6,
      REG_GU_THRESHOLD   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] total_successes;
      logic [15:0] total_failures;
      logic [7:0]  retries_remaining;
      logic [7:0]  failures_in_row;
      logic        attempt_recover;
      logic        quick_rejoin;
      logic        deep_sleep;
      logic        gave_up;
      logic        tx_power_write;
      logic [2:0]  tx_power;
      logic [31:0] rejoin_delay;
      logic        schedule_rejoin;
   } rsp_type;

endpackage

// ----- hdl/rejoin_backoff_controller.sv -----
// Rejoin backoff controller: retry state, backoff delay and power stepping per event.
//
//  channel  direction  payload
//  -------  ---------  ------------------------------------------------------------
//  req_     in         tuser: operation; tdata: channel, is_orphan
//  rsp_     out        tdata: the result fields of one event (see port comment)
//  csr_     in         APB register port, eight registers at byte address 4*index
//
// One event per cycle unless a held result stalls: the state update and result are
// one combinational pass from the event to the result register and the state registers.
// An event is taken whenever the result register is empty or drains in the same cycle.
// rsp_tvalid is registered and rises in the cycle after an event is accepted.
// Synchronous reset loads register defaults and clears the retry state to a fresh backoff.
// CSR writes never touch the retry state; tries and start delay apply at its next reset.
module rejoin_backoff_controller #(
   parameter logic [2:0] MAX_POWER_LEVEL = rbc_pkg::MAX_POWER_LEVEL
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] channel, [5] is_orphan, [7:6] zero
   input  logic [rbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  logic [rbc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] schedule_rejoin, [32:1] rejoin_delay, [35:33] tx_power, [36] tx_power_write,
   // [37] gave_up, [38] deep_sleep, [39] quick_rejoin, [40] attempt_recover,
   // [48:41] failures_in_row, [56:49] retries_remaining, [72:57] total_failures,
   // [88:73] total_successes, [95:89] zero
   output logic [rbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rbc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rbc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import rbc_pkg::*;

   // configuration registers
   logic [1:0]  mode_ff;
   logic [7:0]  tries_ff;
   logic [31:0] start_ff;
   logic [4:0]  factor_ff;
   logic [31:0] max_ff;
   logic [7:0]  ds_thr_ff;
   logic [31:0] ds_int_ff;
   logic [7:0]  gu_thr_ff;

   // retry state
   logic [7:0]  retries_ff,    retries_in;
   logic [31:0] delay_ff,      delay_in;
   logic [7:0]  fail_row_ff,   fail_row_in;
   logic [2:0]  power_ff,      power_in;
   logic        quick_done_ff, quick_done_in;
   logic [4:0]  last_chan_ff,  last_chan_in;
   logic [15:0] fail_tot_ff,   fail_tot_in;
   logic [15:0] succ_tot_ff,   succ_tot_in;

   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   logic          req_accept;
   logic          csr_write;
   reg_index_type csr_index;
   op_type        op;
   logic [4:0]    req_chan;
   logic          req_orphan;
   logic [36:0]   product;

   assign op         = op_type'(req_tuser[1:0]);
   assign req_chan   = req_tdata[4:0];
   assign req_orphan = req_tdata[5];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      case (csr_index)
         REG_TX_POWER_MODE:  csr_prdata = {30'd0, mode_ff};
         REG_RETRY_TRIES:    csr_prdata = {24'd0, tries_ff};
         REG_START_DELAY:    csr_prdata = start_ff;
         REG_BACKOFF_FACTOR: csr_prdata = {27'd0, factor_ff};
         REG_MAX_DELAY:      csr_prdata = max_ff;
         REG_DS_THRESHOLD:   csr_prdata = {24'd0, ds_thr_ff};
         REG_DS_INTERVAL:    csr_prdata = ds_int_ff;
         REG_GU_THRESHOLD:   csr_prdata = {24'd0, gu_thr_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         tries_ff  <= TRIES_RESET;
         start_ff  <= START_RESET;
         factor_ff <= FACTOR_RESET;
         max_ff    <= MAX_RESET;
         ds_thr_ff <= DS_THR_RESET;
         ds_int_ff <= DS_INT_RESET;
         gu_thr_ff <= GU_THR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TX_POWER_MODE:  mode_ff   <= csr_pwdata[1:0];
            REG_RETRY_TRIES:    tries_ff  <= csr_pwdata[7:0];
            REG_START_DELAY:    start_ff  <= csr_pwdata;
            REG_BACKOFF_FACTOR: factor_ff <= csr_pwdata[4:0];
            REG_MAX_DELAY:      max_ff    <= csr_pwdata;
            REG_DS_THRESHOLD:   ds_thr_ff <= csr_pwdata[7:0];
            REG_DS_INTERVAL:    ds_int_ff <= csr_pwdata;
            REG_GU_THRESHOLD:   gu_thr_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign product = delay_ff * {32'd0, factor_ff};

   always_comb begin
      retries_in    = retries_ff;
      delay_in      = delay_ff;
      fail_row_in   = fail_row_ff;
      power_in      = power_ff;
      quick_done_in = quick_done_ff;
      last_chan_in  = last_chan_ff;
      fail_tot_in   = fail_tot_ff;
      succ_tot_in   = succ_tot_ff;
      rsp_in        = '0;

      case (op)
         OP_JOIN_OK: begin
            succ_tot_in   = succ_tot_ff + 16'd1;
            fail_row_in   = '0;
            last_chan_in  = req_chan;
            if (mode_ff == MODE_AUTO && power_ff != 3'd0) begin
               power_in              = '0;
               rsp_in.tx_power_write = 1'b1;
            end
            retries_in    = tries_ff;
            delay_in      = start_ff;
            quick_done_in = 1'b0;
         end
         OP_PARENT_RESTORED: begin
            retries_in    = tries_ff;
            delay_in      = start_ff;
            quick_done_in = 1'b0;
            fail_row_in   = '0;
         end
         OP_REJOIN_FAILED: begin
            fail_tot_in = fail_tot_ff + 16'd1;
            if (fail_row_ff != 8'hFF)
               fail_row_in = fail_row_ff + 8'd1;
            if (mode_ff == MODE_AUTO && power_ff < MAX_POWER_LEVEL) begin
               power_in              = power_ff + 3'd1;
               rsp_in.tx_power_write = 1'b1;
            end
            if (retries_ff != 8'd0) begin
               // saturate the multiplied delay at all ones
               delay_in   = (product[36:32] != 5'd0) ? 32'hFFFF_FFFF : product[31:0];
               retries_in = retries_ff - 8'd1;
            end else begin
               delay_in = max_ff;
            end
            if (fail_row_in >= ds_thr_ff) begin
               delay_in          = ds_int_ff;
               rsp_in.deep_sleep = 1'b1;
            end
            if (fail_row_in >= gu_thr_ff) begin
               rsp_in.gave_up = 1'b1;
            end else begin
               if (!quick_done_ff && last_chan_ff != 5'd0) begin
                  quick_done_in       = 1'b1;
                  rsp_in.quick_rejoin = (last_chan_ff >= CHAN_FIRST) &&
                                        (last_chan_ff <= CHAN_LAST);
               end
               rsp_in.schedule_rejoin = 1'b1;
               rsp_in.rejoin_delay    = delay_in;
            end
         end
         OP_KEY_PRESS: begin
            if (req_orphan) begin
               // clear a run that had given up before trying again
               if (fail_row_ff >= gu_thr_ff) begin
                  fail_row_in   = '0;
                  retries_in    = tries_ff;
                  delay_in      = start_ff;
                  quick_done_in = 1'b0;
               end
               rsp_in.attempt_recover = 1'b1;
            end
         end
         default: ;
      endcase

      rsp_in.tx_power          = power_in;
      rsp_in.failures_in_row   = fail_row_in;
      rsp_in.retries_remaining = retries_in;
      rsp_in.total_failures    = fail_tot_in;
      rsp_in.total_successes   = succ_tot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retries_ff    <= TRIES_RESET;
         delay_ff      <= START_RESET;
         fail_row_ff   <= '0;
         power_ff      <= '0;
         quick_done_ff <= 1'b0;
         last_chan_ff  <= '0;
         fail_tot_ff   <= '0;
         succ_tot_ff   <= '0;
      end else if (req_accept) begin
         retries_ff    <= retries_in;
         delay_ff      <= delay_in;
         fail_row_ff   <= fail_row_in;
         power_ff      <= power_in;
         quick_done_ff <= quick_done_in;
         last_chan_ff  <= last_chan_in;
         fail_tot_ff   <= fail_tot_in;
         succ_tot_ff   <= succ_tot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result until its transaction completes
   always_ff @(posedge clock) begin
      if (req_accept)
         rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted transaction produced no result");

   a_fail_counts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_REJOIN_FAILED) |=>
         (fail_tot_ff == $past(fail_tot_ff) + 16'd1) && (rsp_ff.failures_in_row != 8'd0))
      else $error("failure transaction not counted");

   a_success_counts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_JOIN_OK) |=>
         (succ_tot_ff == $past(succ_tot_ff) + 16'd1) && (fail_row_ff == 8'd0))
      else $error("join success not counted");

   a_no_delay_unscheduled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.schedule_rejoin) |-> (rsp_ff.rejoin_delay == 32'd0))
      else $error("delay reported without a scheduled rejoin");

   a_key_keeps_power: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op == OP_KEY_PRESS || op == OP_PARENT_RESTORED)) |=>
         $stable(power_ff))
      else $error("power changed on an event that must not touch it");
`endif

endmodule
